FILE: design/mtb_pkg.sv
`default_nettype none
package mtb_pkg;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

FILE: design/mtb_cell.sv
`default_nettype none
module mtb_cell
    import mtb_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

FILE: design/mtb_range.sv
`default_nettype none
module mtb_range
    import mtb_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic         i_first,
    input  wire logic [W-1:0] i_pixel,
    output logic      [W-1:0] o_min,
    output logic      [W-1:0] o_max
);

    logic [W-1:0] r_min;
    logic [W-1:0] r_max;
    logic [W-1:0] n_min;
    logic [W-1:0] n_max;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_load) begin
            if (i_first) begin
                n_min = i_pixel;
                n_max = i_pixel;
            end else begin
                if (i_pixel < r_min) begin
                    n_min = i_pixel;
                end
                if (i_pixel > r_max) begin
                    n_max = i_pixel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule
`default_nettype wire

FILE: design/midrange_threshold_binarizer.sv
// Midrange threshold binarizer.
// Input channel: i_valid / o_ready carry one grey pixel (i_pixel_value) per
// request, in raster order, ROWS*COLS requests per frame.
// Output channel: o_valid / i_ready carry one binary pixel per request with
// its raster index (o_pixel_index, low 6 bits) and o_last_pixel on the final
// pixel of the frame.
// Pixels shift into a row of ROWS*COLS cells while darkest and brightest
// values are tracked. After the last pixel the cells shift out from the tail
// and each pixel is compared: 2*pixel >= darkest + brightest.
// Pixels are loaded and emitted in separate phases: a new frame is not
// accepted until every pixel of the previous frame has been shifted out.
// Once the last input pixel is accepted, the first result is registered.
// o_ready is low while a frame is being emitted. A stalled receiver holds
// the output register and the cell row; nothing is dropped.
// Reset: empty frame, darkest = all ones, brightest = 0, no output pending.
`default_nettype none
module midrange_threshold_binarizer
    import mtb_pkg::*;
#(
    parameter int ROWS       = 8,
    parameter int COLS       = 8,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_pixel_value,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_binary_pixel,
    output logic      [5:0] o_pixel_index,
    output logic            o_last_pixel
);

    localparam int FRAME_PIXELS = ROWS * COLS;
    localparam int CNT_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [5:0]            r_idx;
    logic [5:0]            n_idx;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_out_bin;
    logic [5:0]            r_out_idx;
    logic                  r_out_last;

    logic                  w_in_acc;
    logic                  w_emit;
    logic                  w_shift;
    logic                  w_cnt_last;
    logic                  w_bin;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [PIXEL_BITS-1:0] w_head;
    logic [PIXEL_BITS-1:0] w_min;
    logic [PIXEL_BITS-1:0] w_max;
    logic [PIXEL_BITS:0]   w_sum;
    logic [PIXEL_BITS:0]   w_twice;
    logic [PIXEL_BITS-1:0] w_chain [FRAME_PIXELS+1];

    assign w_pix      = PIXEL_BITS'(i_pixel_value);
    assign o_ready    = (r_state == ST_LOAD);
    assign w_in_acc   = i_valid && o_ready;
    assign w_emit     = (r_state == ST_EMIT) && (!r_out_valid || i_ready);
    assign w_shift    = w_in_acc || w_emit;
    assign w_cnt_last = (r_cnt == CNT_W'(FRAME_PIXELS - 1));

    // cell row: new pixels enter at the head, the oldest leaves at the tail
    assign w_head     = (r_state == ST_LOAD) ? w_pix : w_chain[FRAME_PIXELS];
    assign w_chain[0] = w_head;

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_PIXELS; gi++) begin : g_cell
            mtb_cell #(
                .W(PIXEL_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_data (w_chain[gi]),
                .o_data (w_chain[gi+1])
            );
        end
    endgenerate

    mtb_range #(
        .W(PIXEL_BITS)
    ) u_range (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_in_acc),
        .i_first(r_cnt == '0),
        .i_pixel(w_pix),
        .o_min  (w_min),
        .o_max  (w_max)
    );

    assign w_sum   = {1'b0, w_min} + {1'b0, w_max};
    assign w_twice = {w_chain[FRAME_PIXELS], 1'b0};
    assign w_bin   = (w_twice >= w_sum);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = (r_out_valid && !i_ready) || w_emit;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_cnt_last) begin
                        n_cnt   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    if (w_cnt_last) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_bin  <= w_bin;
            r_out_idx  <= r_idx;
            r_out_last <= w_cnt_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_binary_pixel = r_out_bin;
    assign o_pixel_index  = r_out_idx;
    assign o_last_pixel   = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FRAME_PIXELS - 1))
        else $error("pixel counter out of range");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> o_pixel_index == 6'(FRAME_PIXELS - 1))
        else $error("last flag on wrong index");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_cnt_last |=> !o_ready && r_cnt == '0)
        else $error("frame end did not start output run");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_cnt_last |=> o_ready && o_valid && o_last_pixel)
        else $error("output run did not end cleanly");

endmodule
`default_nettype wire
